FILE: src/sliding_window_mean_variance_macros.svh
// Assertion macros shared by the sliding window mean and variance block.
`ifndef SLIDING_WINDOW_MEAN_VARIANCE_MACROS_SVH
`define SLIDING_WINDOW_MEAN_VARIANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWMV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/swmv_pkg.sv
// Types and fixed constants shared by the sliding window mean and variance block.
`default_nettype none

package swmv_pkg;

   localparam int CFG_W       = 9;
   localparam int COUNT_OUT_W = 9;
   localparam int MEAN_W      = 32;
   localparam int DEV_W       = 56;

   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_NEW,
      ST_SQ_OLD,
      ST_UPDATE,
      ST_SUMSQ,
      ST_DIV_MEAN,
      ST_DIV_VAR,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MUL_SAMPLE,
      MUL_OLD,
      MUL_SUM
   } mul_sel_type;

   typedef enum logic {
      DIV_SEL_MEAN,
      DIV_SEL_VAR
   } div_sel_type;

   typedef struct packed {
      logic        take_sample;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sqx_take;
      logic        update;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_mean;
      logic        take_var;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

FILE: src/swmv_if.sv
// Channel interfaces: sample requests, result responses and the window size write port.
`default_nettype none

interface swmv_req_if #(parameter int SAMPLE_BITS = 24) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swmv_rsp_if
   import swmv_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   accepted;
   logic [COUNT_OUT_W-1:0] window_count;
   logic [MEAN_W-1:0]      mean_fixed;
   logic [DEV_W-1:0]       sq_dev_sum;

   modport source (output valid, output accepted, output window_count,
                   output mean_fixed, output sq_dev_sum, input ready);
   modport sink   (input valid, input accepted, input window_count,
                   input mean_fixed, input sq_dev_sum, output ready);
endinterface

interface swmv_csr_if
   import swmv_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

FILE: src/swmv_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module swmv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/swmv_div.sv
// Iterative unsigned divider that retires RADIX quotient bits per cycle.
`default_nettype none

module swmv_div #(
   parameter int DIVIDEND_W = 64,
   parameter int DIVISOR_W  = 9,
   parameter int RADIX      = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       busy,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient,
   output logic                       rem_nonzero
);

   localparam int PAD_W = ((DIVIDEND_W + RADIX - 1) / RADIX) * RADIX;
   localparam int STEPS = PAD_W / RADIX;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PAD_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [PAD_W-1:0]     quo_step;
   logic [DIVISOR_W-1:0] rem_step;

   // Restoring division: the partial remainder stays below the divisor,
   // so every step is a narrow compare and subtract.
   always_comb begin
      logic [DIVISOR_W:0] trial;
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int i = 0; i < RADIX; i++) begin
         trial    = {rem_step, quo_step[PAD_W-1]};
         quo_step = {quo_step[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial       = trial - {1'b0, divisor_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = trial[DIVISOR_W-1:0];
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = PAD_W'(dividend);
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy        = busy_ff;
   assign done        = done_ff;
   assign quotient    = quo_ff[DIVIDEND_W-1:0];
   assign rem_nonzero = |rem_ff;

endmodule

`default_nettype wire

FILE: src/swmv_ctrl.sv
// Sequencer for one sample transaction: squares, window update, two divisions, result hand-off.
`default_nettype none

module swmv_ctrl
   import swmv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire status_type  status,
   output cmd_type          cmd
);

`include "sliding_window_mean_variance_macros.svh"

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can be loaded when it is empty or drains this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQ_NEW;
            end
         end
         ST_SQ_NEW:   state_in = ST_SQ_OLD;
         ST_SQ_OLD:   state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_SUMSQ;
         ST_SUMSQ:    state_in = ST_DIV_MEAN;
         ST_DIV_MEAN: begin
            if (status.div_done) begin
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.take_sample = req_valid;
         end
         ST_SQ_NEW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SAMPLE;
         end
         ST_SQ_OLD: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_OLD;
            cmd.sqx_take = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_SUMSQ: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_SUM;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_MEAN;
         end
         ST_DIV_MEAN: begin
            cmd.take_mean = status.div_done;
            cmd.div_start = status.div_done;
            cmd.div_sel   = DIV_SEL_VAR;
         end
         ST_DIV_VAR: begin
            cmd.take_var = status.div_done;
         end
         ST_EMIT: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SWMV_ASSERT_NOW(a_done_in_div_state, clock, reset, status.div_done,
      state_ff == ST_DIV_MEAN || state_ff == ST_DIV_VAR,
      "divider finished outside a division state")
   `SWMV_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.load_out,
      rsp_valid_ff && state_ff == ST_IDLE,
      "loaded result not presented or sequencer not back to idle")

endmodule

`default_nettype wire

FILE: src/swmv_dp.sv
// Datapath: sample ring, exact sum and sum of squares, shared squarer and divider, result register.
`default_nettype none

module swmv_dp
   import swmv_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int WINDOW_DEPTH   = 256,
   parameter int MEAN_FRAC_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                   csr_write,
   input  wire logic [CFG_W-1:0]       csr_window_size,
   output logic                        rsp_accepted,
   output logic [COUNT_OUT_W-1:0]      rsp_window_count,
   output logic [MEAN_W-1:0]           rsp_mean_fixed,
   output logic [DEV_W-1:0]            rsp_sq_dev_sum
);

`include "sliding_window_mean_variance_macros.svh"

   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int CW     = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + AW;
   localparam int SQ_W   = 2 * SAMPLE_BITS + AW;
   localparam int SQX_W  = 2 * SAMPLE_BITS;
   localparam int PROD_W = 2 * SUM_W;
   localparam int MDIV_W = SUM_W + MEAN_FRAC_BITS;
   localparam int DIV_W  = (PROD_W > MDIV_W) ? PROD_W : MDIV_W;
   localparam int C2_W   = DIV_W + 1;
   localparam int CAPX_W = (CW > CFG_W) ? CW : CFG_W;
   localparam int QX_W   = (DIV_W > MEAN_W) ? DIV_W : MEAN_W + 1;
   localparam int DX_W   = (SQ_W > C2_W) ? SQ_W : C2_W;

   logic [CFG_W-1:0]       ws_ff, ws_in;
   logic [AW-1:0]          wp_ff, wp_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SQX_W-1:0]       sqx_ff, sqx_in;
   logic                   acc_ff, acc_in;
   logic [MEAN_W-1:0]      mean_ff, mean_in;
   logic [C2_W-1:0]        c2_ff, c2_in;
   logic                   out_acc_ff, out_acc_in;
   logic [COUNT_OUT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [MEAN_W-1:0]      out_mean_ff, out_mean_in;
   logic [DEV_W-1:0]       out_dev_ff, out_dev_in;

   logic [CAPX_W-1:0]      cap_x;
   logic [CW-1:0]          cap;
   logic                   cap_zero;
   logic                   full;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic [SAMPLE_BITS-1:0] old_v;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [CW-1:0]          wp_inc;
   logic [AW-1:0]          wp_wrap;
   logic [SUM_W-1:0]       mul_a;
   logic [PROD_W-1:0]      prod_v;
   logic [DIV_W-1:0]       div_dividend;
   logic [DIV_W-1:0]       div_quotient;
   logic                   div_rem_nz;
   logic                   div_busy;
   logic                   div_done;
   logic [QX_W-1:0]        quo_x;
   logic [DX_W-1:0]        sq_x;
   logic [DX_W-1:0]        c2_x;
   logic [DX_W-1:0]        dev_v;

   // Window sizes beyond the store depth use the whole store.
   always_comb begin
      cap_x = CAPX_W'(ws_ff);
      if (cap_x > CAPX_W'(WINDOW_DEPTH)) begin
         cap_x = CAPX_W'(WINDOW_DEPTH);
      end
   end
   assign cap      = cap_x[CW-1:0];
   assign cap_zero = (cap == '0);
   assign full     = (fill_ff >= cap);

   // The read port always looks at the oldest slot; it only matters once the ring is full.
   swmv_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (x_ff),
      .rd_addr (wp_ff),
      .rd_data (ram_rd_data)
   );

   assign old_v       = full ? ram_rd_data : '0;
   assign ram_wr_en   = cmd.update && !cap_zero;
   assign ram_wr_addr = full ? wp_ff : fill_ff[AW-1:0];
   assign wp_inc      = CW'(wp_ff) + CW'(1);
   assign wp_wrap     = (wp_inc >= cap) ? '0 : wp_inc[AW-1:0];

   // One shared squarer serves the new sample, the evicted sample and the sum.
   always_comb begin
      case (cmd.mul_sel)
         MUL_SAMPLE: mul_a = SUM_W'(x_ff);
         MUL_OLD:    mul_a = SUM_W'(old_v);
         MUL_SUM:    mul_a = sum_ff;
         default:    mul_a = '0;
      endcase
   end
   assign prod_v = mul_a * mul_a;

   always_comb begin
      div_dividend = DIV_W'(prod_ff);
      if (cmd.div_sel == DIV_SEL_MEAN) begin
         div_dividend = DIV_W'(sum_ff) << MEAN_FRAC_BITS;
      end
   end

   swmv_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (CW),
      .RADIX      (4)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .dividend    (div_dividend),
      .divisor     (fill_ff),
      .busy        (div_busy),
      .done        (div_done),
      .quotient    (div_quotient),
      .rem_nonzero (div_rem_nz)
   );

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;

   // sum^2 / n is rounded up so the deviation sum comes out floored.
   assign quo_x = QX_W'(div_quotient);
   assign sq_x  = DX_W'(sq_ff);
   assign c2_x  = DX_W'(c2_ff);
   assign dev_v = (fill_ff == '0 || sq_x < c2_x) ? '0 : sq_x - c2_x;

   always_comb begin
      ws_in   = ws_ff;
      wp_in   = wp_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      acc_in  = acc_ff;
      if (csr_write) begin
         ws_in   = csr_window_size;
         wp_in   = '0;
         fill_in = '0;
         sum_in  = '0;
         sq_in   = '0;
      end else if (cmd.update) begin
         acc_in = !cap_zero;
         if (!cap_zero) begin
            // While filling, the evicted sample and its square are both zero.
            sum_in = sum_ff + SUM_W'(x_ff) - SUM_W'(old_v);
            sq_in  = sq_ff + SQ_W'(sqx_ff) - SQ_W'(prod_ff);
            if (full) begin
               wp_in   = wp_wrap;
               fill_in = cap;
            end else begin
               fill_in = fill_ff + CW'(1);
            end
         end
      end
   end

   always_comb begin
      x_in        = cmd.take_sample ? req_sample : x_ff;
      prod_in     = cmd.mul_en ? prod_v : prod_ff;
      sqx_in      = cmd.sqx_take ? prod_ff[SQX_W-1:0] : sqx_ff;
      mean_in     = mean_ff;
      c2_in       = cmd.take_var ? C2_W'(div_quotient) + C2_W'(div_rem_nz) : c2_ff;
      out_acc_in  = out_acc_ff;
      out_cnt_in  = out_cnt_ff;
      out_mean_in = out_mean_ff;
      out_dev_in  = out_dev_ff;
      if (cmd.take_mean) begin
         if (fill_ff == '0) begin
            mean_in = '0;
         end else if (quo_x > QX_W'({MEAN_W{1'b1}})) begin
            mean_in = '1;
         end else begin
            mean_in = MEAN_W'(div_quotient);
         end
      end
      if (cmd.load_out) begin
         out_acc_in  = acc_ff;
         out_cnt_in  = COUNT_OUT_W'(fill_ff);
         out_mean_in = mean_ff;
         out_dev_in  = DEV_W'(dev_v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= WINDOW_SIZE_RESET;
         wp_ff   <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
      end else begin
         ws_ff   <= ws_in;
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      sqx_ff      <= sqx_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      c2_ff       <= c2_in;
      out_acc_ff  <= out_acc_in;
      out_cnt_ff  <= out_cnt_in;
      out_mean_ff <= out_mean_in;
      out_dev_ff  <= out_dev_in;
   end

   assign rsp_accepted     = out_acc_ff;
   assign rsp_window_count = out_cnt_ff;
   assign rsp_mean_fixed   = out_mean_ff;
   assign rsp_sq_dev_sum   = out_dev_ff;

   `SWMV_ASSERT_NOW(a_fill_within_cap, clock, reset, 1'b1, fill_ff <= cap,
      "window count exceeds the active capacity")
   `SWMV_ASSERT_NOW(a_div_start_idle, clock, reset, cmd.div_start, !div_busy,
      "division started while the divider is still busy")

endmodule

`default_nettype wire

FILE: src/sliding_window_mean_variance.sv
// Top level of the sliding window mean and variance block.
// Usage:
//   req_ch carries one duration sample per transaction. Each accepted sample
//   enters a ring of the last window_size samples (oldest one replaced when
//   full) and produces exactly one transaction on rsp_ch: accepted, the
//   window count, the floored mean with MEAN_FRAC_BITS fraction bits and the
//   floored sum of squared deviations from the exact window mean.
//   csr_ch writes window_size (always ready); a write clears the window and
//   must only happen while no sample is in flight. Zero drops all samples.
// Timing:
//   One sample at a time. Each transaction squares the new and the evicted
//   samples, updates the window and squares the sum, then runs the shared
//   4-bit-per-cycle divider on DW = max(2 * (SAMPLE_BITS + log2 depth),
//   SAMPLE_BITS + log2 depth + MEAN_FRAC_BITS) bit dividends, once for the
//   mean and once for the deviation sum.
// Reset clears the window and sets window_size to 256. The result sits in an
//   output register; a stalled receiver holds it there, and the next sample
//   is taken but waits at its final step until that register drains.
`default_nettype none

module sliding_window_mean_variance
   import swmv_pkg::*;
#(
   parameter int WINDOW_DEPTH   = 256,
   parameter int SAMPLE_BITS    = 24,
   parameter int MEAN_FRAC_BITS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   swmv_req_if.sink    req_ch,
   swmv_rsp_if.source  rsp_ch,
   swmv_csr_if.sink    csr_ch
);

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   swmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swmv_dp #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .WINDOW_DEPTH   (WINDOW_DEPTH),
      .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_ch.sample),
      .csr_write        (csr_write),
      .csr_window_size  (csr_ch.window_size),
      .rsp_accepted     (rsp_ch.accepted),
      .rsp_window_count (rsp_ch.window_count),
      .rsp_mean_fixed   (rsp_ch.mean_fixed),
      .rsp_sq_dev_sum   (rsp_ch.sq_dev_sum)
   );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the sliding window mean and variance block.
`timescale 1ns / 100ps

module tb_top
   import swmv_pkg::*;
();

   localparam int DEPTH      = 256;
   localparam int SAMPLE_W   = 24;
   localparam int FRAC_BITS  = 8;
   localparam int RAND_ITEMS = 1650;

   typedef struct packed {
      logic                   accepted;
      logic [COUNT_OUT_W-1:0] window_count;
      logic [MEAN_W-1:0]      mean_fixed;
      logic [DEV_W-1:0]       sq_dev_sum;
   } window_stats_type;

   typedef enum logic {ROW_PUSH, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] value;
      bit                  pinned;
      window_stats_type    want;
   } row_type;

   typedef enum logic [1:0] {
      SINK_FREE,
      SINK_RANDOM,
      SINK_PERIODIC,
      SINK_BLOCKED
   } sink_mode_type;

   localparam logic [SAMPLE_W-1:0] SMAX = {SAMPLE_W{1'b1}};

   // Pinned rows carry results that follow directly from the window contents.
   row_type directed_rows [25] = '{
      '{ROW_PUSH, 24'd0,  1'b1, '{1'b1, 9'd1, 32'd0, 56'd0}},
      '{ROW_PUSH, SMAX,   1'b0, '0},
      '{ROW_PUSH, 24'd1,  1'b0, '0},
      '{ROW_CFG,  24'd0,  1'b0, '0},
      '{ROW_PUSH, 24'd5,  1'b1, '{1'b0, 9'd0, 32'd0, 56'd0}},
      '{ROW_PUSH, SMAX,   1'b1, '{1'b0, 9'd0, 32'd0, 56'd0}},
      '{ROW_CFG,  24'd1,  1'b0, '0},
      '{ROW_PUSH, SMAX,   1'b1, '{1'b1, 9'd1, 32'hFFFF_FF00, 56'd0}},
      '{ROW_PUSH, 24'd7,  1'b1, '{1'b1, 9'd1, 32'h0000_0700, 56'd0}},
      '{ROW_CFG,  24'd2,  1'b0, '0},
      '{ROW_PUSH, SMAX,   1'b1, '{1'b1, 9'd1, 32'hFFFF_FF00, 56'd0}},
      '{ROW_PUSH, SMAX,   1'b1, '{1'b1, 9'd2, 32'hFFFF_FF00, 56'd0}},
      '{ROW_PUSH, 24'd0,  1'b0, '0},
      '{ROW_PUSH, 24'd0,  1'b1, '{1'b1, 9'd2, 32'd0, 56'd0}},
      '{ROW_CFG,  24'd511, 1'b0, '0},
      '{ROW_PUSH, 24'd10, 1'b1, '{1'b1, 9'd1, 32'h0000_0A00, 56'd0}},
      '{ROW_PUSH, 24'd20, 1'b0, '0},
      '{ROW_CFG,  24'd3,  1'b0, '0},
      '{ROW_PUSH, 24'd3,  1'b0, '0},
      '{ROW_PUSH, 24'd6,  1'b0, '0},
      '{ROW_PUSH, 24'd9,  1'b0, '0},
      '{ROW_PUSH, 24'd12, 1'b0, '0},
      '{ROW_PUSH, SMAX,   1'b0, '0},
      '{ROW_CFG,  24'd256, 1'b0, '0},
      '{ROW_PUSH, SMAX,   1'b1, '{1'b1, 9'd1, 32'hFFFF_FF00, 56'd0}}
   };

   logic clock;
   logic reset;

   swmv_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_ch ();
   swmv_rsp_if                           rsp_ch ();
   swmv_csr_if                           csr_ch ();

   sliding_window_mean_variance i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the window.
   logic [SAMPLE_W-1:0] win_mem [DEPTH];
   int unsigned         win_wr_ptr;
   int unsigned         win_fill;
   int unsigned         win_size;
   bit [63:0]           win_sum;
   bit [63:0]           win_sq_sum;

   window_stats_type stats_due_q [$];
   int               mismatch_count = 0;
   int               burst_left = 0;

   sink_mode_type sink_mode = SINK_FREE;
   int unsigned   sink_span = 0;

   function automatic window_stats_type window_report(logic acc);
      bit [63:0]        n, q, r, sub, m;
      window_stats_type s;
      n = 64'(win_fill);
      s.accepted     = acc;
      s.window_count = COUNT_OUT_W'(win_fill);
      s.mean_fixed   = '0;
      s.sq_dev_sum   = '0;
      if (n != 0) begin
         q   = win_sum / n;
         r   = win_sum % n;
         // Subtract sum^2 / n rounded up so that the deviation sum is floored.
         sub = q * q * n + 2 * q * r + (r * r + n - 1) / n;
         m   = (win_sum << FRAC_BITS) / n;
         s.mean_fixed = (m > 64'hFFFF_FFFF) ? '1 : m[MEAN_W-1:0];
         s.sq_dev_sum = (win_sq_sum >= sub) ? DEV_W'(win_sq_sum - sub) : '0;
      end
      return s;
   endfunction

   function automatic window_stats_type window_push(logic [SAMPLE_W-1:0] x);
      int unsigned cap;
      bit [63:0]   old, xv;
      cap = (win_size > DEPTH) ? DEPTH : win_size;
      xv  = 64'(x);
      if (cap == 0)
         return window_report(1'b0);
      if (win_fill >= cap) begin
         old        = 64'(win_mem[win_wr_ptr % DEPTH]);
         win_sum    = win_sum - old + xv;
         win_sq_sum = win_sq_sum - old * old + xv * xv;
         win_mem[win_wr_ptr % DEPTH] = x;
         win_wr_ptr = (win_wr_ptr + 1 >= cap) ? 0 : win_wr_ptr + 1;
      end else begin
         win_mem[win_fill % DEPTH] = x;
         win_fill++;
         win_sum    = win_sum + xv;
         win_sq_sum = win_sq_sum + xv * xv;
      end
      return window_report(1'b1);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] x;
      case ($urandom_range(0, 7))
         0: x = '0;
         1: x = SMAX;
         2: x = SAMPLE_W'($urandom_range(0, 255));
         3: x = SMAX - SAMPLE_W'($urandom_range(0, 255));
         default: x = SAMPLE_W'($urandom());
      endcase
      return x;
   endfunction

   // Leaves valid high after the transaction; the caller either sends again at once
   // or the gap logic here lowers it.
   task automatic send_sample(logic [SAMPLE_W-1:0] x, bit pinned, window_stats_type want);
      window_stats_type pred;
      req_ch.valid  <= 1'b1;
      req_ch.sample <= x;
      do @(posedge clock); while (!req_ch.ready);
      pred = window_push(x);
      if (pinned)
         pred = want;
      stats_due_q = {stats_due_q, pred};
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic set_window_size(logic [CFG_W-1:0] v);
      req_ch.valid <= 1'b0;
      while (stats_due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.window_size <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      win_size   = v;
      win_wr_ptr = 0;
      win_fill   = 0;
      win_sum    = '0;
      win_sq_sum = '0;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: switches between stall patterns in stretches of random length.
   always @(posedge clock) begin
      int pick;
      if (sink_span == 0) begin
         pick = $urandom_range(0, 5);
         sink_mode <= (pick < 3) ? SINK_FREE : sink_mode_type'(pick - 2);
         sink_span <= $urandom_range(10, 60);
      end else begin
         sink_span <= sink_span - 1;
      end
      case (sink_mode)
         SINK_FREE:     rsp_ch.ready <= 1'b1;
         SINK_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         SINK_PERIODIC: rsp_ch.ready <= (sink_span[2:0] < 3'd3);
         default:       rsp_ch.ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      window_stats_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (stats_due_q.size() == 0) begin
            $error("unexpected response transaction");
            mismatch_count++;
         end else begin
            want = stats_due_q.pop_front();
            if (rsp_ch.accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_ch.accepted);
               mismatch_count++;
            end
            if (rsp_ch.window_count !== want.window_count) begin
               $error("window_count: expected %0d, got %0d",
                      want.window_count, rsp_ch.window_count);
               mismatch_count++;
            end
            if (rsp_ch.mean_fixed !== want.mean_fixed) begin
               $error("mean_fixed: expected %0h, got %0h",
                      want.mean_fixed, rsp_ch.mean_fixed);
               mismatch_count++;
            end
            if (rsp_ch.sq_dev_sum !== want.sq_dev_sum) begin
               $error("sq_dev_sum: expected %0h, got %0h",
                      want.sq_dev_sum, rsp_ch.sq_dev_sum);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned sz, cap, len, rand_sent;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.sample      <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.window_size <= '0;
      foreach (win_mem[i]) win_mem[i] = '0;
      win_wr_ptr = 0;
      win_fill   = 0;
      win_sum    = '0;
      win_sq_sum = '0;
      win_size   = WINDOW_SIZE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG)
            set_window_size(CFG_W'(directed_rows[i].value));
         else
            send_sample(directed_rows[i].value, directed_rows[i].pinned,
                        directed_rows[i].want);
      end

      // Start with a full-depth window long enough to wrap the ring.
      set_window_size(CFG_W'(DEPTH));
      for (int i = 0; i < 320; i++)
         send_sample(pick_sample(), 1'b0, '0);
      rand_sent = 320;

      while (rand_sent < RAND_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       sz = 0;
            1:       sz = DEPTH;
            2:       sz = $urandom_range(DEPTH + 1, 511);
            3, 4, 5: sz = $urandom_range(1, 8);
            6, 7:    sz = $urandom_range(9, 64);
            default: sz = $urandom_range(65, DEPTH - 1);
         endcase
         cap = (sz > DEPTH) ? DEPTH : sz;
         len = (cap > 64) ? cap + $urandom_range(10, 80) : $urandom_range(15, 100);
         if (len > RAND_ITEMS - rand_sent)
            len = RAND_ITEMS - rand_sent;
         set_window_size(CFG_W'(sz));
         for (int i = 0; i < len; i++)
            send_sample(pick_sample(), 1'b0, '0);
         rand_sent += len;
      end

      req_ch.valid <= 1'b0;
      while (stats_due_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/swmv_pkg.sv
src/swmv_if.sv
src/swmv_ram.sv
src/swmv_div.sv
src/swmv_ctrl.sv
src/swmv_dp.sv
src/sliding_window_mean_variance.sv
bench/tb_top.sv
